// File: design/assert_macros.svh
// Assertion macros shared by the touch median filter modules.
// Each macro expects signals named clk and arst_n in the enclosing scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// A condition that must hold at every clock edge out of reset.
`define TMF_ASSERT_ALWAYS(label, cond, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (cond)) else $error(msg);

// A condition that, once true, must be followed in the next cycle by another.
`define TMF_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// File: design/tmf_pkg.sv
// ----------------------------------------------------------------------------
// tmf_pkg
// Types and constants shared by the touch median filter modules.
// ----------------------------------------------------------------------------
package tmf_pkg;

	localparam int unsigned WORD_W   = 16;
	localparam int unsigned SAMPLE_W = 13;
	localparam int unsigned POS_W    = 11;

	typedef struct packed {
		logic [WORD_W-1:0] x_word;
		logic [WORD_W-1:0] y_word;
		logic              pen_down;
	} in_item_t;

	typedef struct packed {
		logic             point_valid;
		logic [POS_W-1:0] x_pos;
		logic [POS_W-1:0] y_pos;
	} out_item_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_INS_X,
		ST_INS_Y,
		ST_DONE
	} state_t;

	// Commands from the sequencer to the insertion unit.
	typedef struct packed {
		logic load;
		logic run;
		logic axis;
	} srt_ctl_t;

	// Status from the insertion unit back to the sequencer.
	typedef struct packed {
		logic             placed;
		logic [POS_W-1:0] x_pos;
		logic [POS_W-1:0] y_pos;
	} srt_stat_t;

endpackage

// File: design/tmf_sorter.sv
// ----------------------------------------------------------------------------
// tmf_sorter
// Keeps both sample buffers in ascending order by insertion: a single
// comparator moves one entry up per cycle until the new key finds its place.
// ----------------------------------------------------------------------------
module tmf_sorter #(
	parameter int unsigned SAMPLES = 10,
	parameter int unsigned IDX_W   = 4
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  tmf_pkg::srt_ctl_t         ctl,
	input  logic [IDX_W-1:0]          count,
	input  tmf_pkg::in_item_t         item,
	output tmf_pkg::srt_stat_t        stat
);
	import tmf_pkg::*;

	localparam int unsigned MID = SAMPLES / 2;

	logic [SAMPLE_W-1:0] x_buf_q [SAMPLES];
	logic [SAMPLE_W-1:0] y_buf_q [SAMPLES];
	logic [SAMPLE_W-1:0] key_x_q;
	logic [SAMPLE_W-1:0] key_y_q;
	logic [IDX_W-1:0]    hole_q;

	logic [IDX_W-1:0]    prev;
	logic [SAMPLE_W-1:0] cmp_val;
	logic [SAMPLE_W-1:0] key;
	logic                shift;
	logic [SAMPLE_W-1:0] wr_val;
	logic [SAMPLE_W:0]   x_sum;
	logic [SAMPLE_W:0]   y_sum;

	assign prev    = hole_q - 1'b1;
	assign cmp_val = ctl.axis ? y_buf_q[prev] : x_buf_q[prev];
	assign key     = ctl.axis ? key_y_q : key_x_q;
	// The hole moves down while the entry below it is larger than the key.
	assign shift   = (hole_q != '0) && (cmp_val > key);
	assign wr_val  = shift ? cmp_val : key;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hole_q <= '0;
		end else if (ctl.load) begin
			hole_q <= count;
		end else if (ctl.run) begin
			hole_q <= shift ? prev : count;
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.load) begin
			key_x_q <= item.x_word[WORD_W-1:WORD_W-SAMPLE_W];
			key_y_q <= item.y_word[WORD_W-1:WORD_W-SAMPLE_W];
		end
		if (ctl.run) begin
			if (ctl.axis) begin
				y_buf_q[hole_q] <= wr_val;
			end else begin
				x_buf_q[hole_q] <= wr_val;
			end
		end
	end

	assign x_sum = {1'b0, x_buf_q[MID-1]} + {1'b0, x_buf_q[MID]};
	assign y_sum = {1'b0, y_buf_q[MID-1]} + {1'b0, y_buf_q[MID]};

	assign stat.placed = ctl.run && !shift;
	assign stat.x_pos  = x_sum[SAMPLE_W:3];
	assign stat.y_pos  = y_sum[SAMPLE_W:3];

	`include "assert_macros.svh"

	`TMF_ASSERT_ALWAYS(a_hole_in_range, !ctl.run || hole_q <= count, "hole beyond the count")
	`TMF_ASSERT_NEXT(a_reload_after_place, stat.placed, hole_q == count, "hole not reloaded")

endmodule

// File: design/tmf_ctrl.sv
// ----------------------------------------------------------------------------
// tmf_ctrl
// Sequencer for the touch median filter: takes a sample, runs the insertion
// for each axis, then decides on a point, an abort or no result.
// ----------------------------------------------------------------------------
module tmf_ctrl #(
	parameter int unsigned SAMPLES = 10,
	parameter int unsigned IDX_W   = 4
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                smp_valid,
	output logic                smp_ready,
	input  logic                pen_down,
	output logic                res_valid,
	input  logic                res_ready,
	output tmf_pkg::out_item_t  res_data,
	output tmf_pkg::srt_ctl_t   ctl,
	output logic [IDX_W-1:0]    count,
	input  tmf_pkg::srt_stat_t  stat
);
	import tmf_pkg::*;

	localparam int unsigned CNT_W = $clog2(SAMPLES + 1);

	state_t           state_q;
	state_t           state_d;
	logic [IDX_W-1:0] count_q;
	logic             pen_q;
	logic             res_valid_q;
	out_item_t        res_data_q;

	logic [CNT_W-1:0] cnt_next;
	logic             full;
	logic             emit;
	logic             can_go;
	logic             finish;

	assign cnt_next = CNT_W'(count_q) + 1'b1;
	assign full     = (cnt_next == CNT_W'(SAMPLES));
	assign emit     = full || !pen_q;
	// A new result may only be written once the previous one has been transferred.
	assign can_go   = !emit || !res_valid_q || res_ready;
	assign finish   = (state_q == ST_DONE) && can_go;

	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (smp_valid) state_d = ST_INS_X;
			end
			ST_INS_X: begin
				if (stat.placed) state_d = ST_INS_Y;
			end
			ST_INS_Y: begin
				if (stat.placed) state_d = ST_DONE;
			end
			ST_DONE: begin
				if (can_go) state_d = ST_IDLE;
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		smp_ready = (state_q == ST_IDLE);
		ctl.load  = smp_valid && (state_q == ST_IDLE);
		ctl.run   = (state_q == ST_INS_X) || (state_q == ST_INS_Y);
		ctl.axis  = (state_q == ST_INS_Y);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			count_q     <= '0;
			res_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (finish) begin
				count_q <= emit ? '0 : IDX_W'(cnt_next);
			end
			if (finish && emit) begin
				res_valid_q <= 1'b1;
			end else if (res_ready) begin
				res_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (smp_valid && smp_ready) begin
			pen_q <= pen_down;
		end
		if (finish && emit) begin
			res_data_q.point_valid <= full;
			res_data_q.x_pos       <= full ? stat.x_pos : '0;
			res_data_q.y_pos       <= full ? stat.y_pos : '0;
		end
	end

	assign res_valid = res_valid_q;
	assign res_data  = res_data_q;
	assign count     = count_q;

	`include "assert_macros.svh"

	`TMF_ASSERT_ALWAYS(a_count_below_set, CNT_W'(count_q) < CNT_W'(SAMPLES), "sample count reached the set size")
	`TMF_ASSERT_ALWAYS(a_abort_zero, !res_valid_q || res_data_q.point_valid || (res_data_q.x_pos == '0 && res_data_q.y_pos == '0), "abort result carries a position")
	`TMF_ASSERT_NEXT(a_result_clears, finish && emit, count_q == '0 && res_valid_q, "result did not clear the count")

endmodule

// File: design/touch_median_filter.sv
// ----------------------------------------------------------------------------
// touch_median_filter
// Collects touch sample pairs and gives the mean of the two middle sorted
// samples per axis once a full set is held, or an abort when the pen lifts.
// ----------------------------------------------------------------------------
// A result is registered in the done step, after the insertion for x and then
// for y. No new sample is taken until the sequencer is back in its idle step;
// the single comparator moves one entry a cycle, and a result not yet
// transferred holds the sequencer in its last step when a new one is due.
// Reset clears the sample count and the sequencer; buffer contents are kept.
// ----------------------------------------------------------------------------
module touch_median_filter #(
	parameter int unsigned SAMPLES = 10
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                smp_valid,
	output logic                smp_ready,
	input  tmf_pkg::in_item_t   smp_data,
	output logic                res_valid,
	input  logic                res_ready,
	output tmf_pkg::out_item_t  res_data
);
	import tmf_pkg::*;

	localparam int unsigned IDX_W = $clog2(SAMPLES);

	srt_ctl_t         ctl;
	srt_stat_t        stat;
	logic [IDX_W-1:0] count;

	tmf_ctrl #(
		.SAMPLES (SAMPLES),
		.IDX_W   (IDX_W)
	) u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.smp_valid (smp_valid),
		.smp_ready (smp_ready),
		.pen_down  (smp_data.pen_down),
		.res_valid (res_valid),
		.res_ready (res_ready),
		.res_data  (res_data),
		.ctl       (ctl),
		.count     (count),
		.stat      (stat)
	);

	tmf_sorter #(
		.SAMPLES (SAMPLES),
		.IDX_W   (IDX_W)
	) u_sorter (
		.clk    (clk),
		.arst_n (arst_n),
		.ctl    (ctl),
		.count  (count),
		.item   (smp_data),
		.stat   (stat)
	);

endmodule
